// ----- sv/skinned_mesh_partitioner_unit_defines.svh -----
// Assertion macros for the skinned mesh partitioner checker.
// No dependencies.
`ifndef SKINNED_MESH_PARTITIONER_UNIT_DEFINES_SVH
`define SKINNED_MESH_PARTITIONER_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SMP_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("smp check failed");

// Next-cycle implication, held off during reset.
`define SMP_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("smp check failed");

`endif

// ----- sv/smp_pkg.sv -----
// Shared types and constants of the skinned mesh partitioner.
// No dependencies.
`timescale 1ns / 1ps

package smp_pkg;

  localparam int VertexLimit = 65535;
  localparam int QueueDepth  = 2;

  localparam logic [1:0] KIND_VERTEX  = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_CLOSE   = 2'd2;

  typedef struct packed {
    logic [2:0][15:0]      vtx;
    logic [2:0][3:0][9:0]  bone;
    logic                  mat_end;
    logic [15:0]           lo;
    logic [15:0]           hi;
  } tri_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [15:0]      local_vertex;
    logic             is_new;
    logic [3:0][5:0]  slots;
    logic [5:0]       palette_slot;
    logic [9:0]       global_bone;
    logic [7:0]       material_index;
    logic [6:0]       bone_count;
    logic             last;
  } res_t;

endpackage

// ----- sv/smp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module smp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  // Contents start at zero; users must not depend on it for correctness.
  logic [WIDTH-1:0] mem [DEPTH] = '{default: '0};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/smp_front.sv -----
// Front end: unpacks an incoming triangle and finds its vertex index span.
// Depends on smp_pkg.
`timescale 1ns / 1ps

module smp_front
  import smp_pkg::*;
(
  input  logic [167:0] tdata,
  input  logic         tlast,
  output tri_t         tri_out
);

  logic [15:0] va, vb, vc;
  logic [15:0] lo_ab, hi_ab;

  assign va = tdata[15:0];
  assign vb = tdata[31:16];
  assign vc = tdata[47:32];

  assign lo_ab = (vb < va) ? vb : va;
  assign hi_ab = (vb > va) ? vb : va;

  always_comb begin
    tri_out         = '0;
    tri_out.vtx[0]  = va;
    tri_out.vtx[1]  = vb;
    tri_out.vtx[2]  = vc;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        tri_out.bone[i][j] = tdata[48 + 40*i + 10*j +: 10];
      end
    end
    tri_out.mat_end = tlast;
    tri_out.lo      = (vc < lo_ab) ? vc : lo_ab;
    tri_out.hi      = (vc > hi_ab) ? vc : hi_ab;
  end

endmodule

// ----- sv/smp_queue.sv -----
// Two-entry triangle queue between front and back end.
// Depends on smp_pkg.
`timescale 1ns / 1ps

module smp_queue
  import smp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tri_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output tri_t head
);

  localparam int AW = $clog2(QueueDepth);

  tri_t           mem [QueueDepth];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;

  assign full      = (count == (AW+1)'(QueueDepth));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ----- sv/smp_back.sv -----
// Back end: per-triangle sequencer over the vertex and bone maps, with the output register.
// Depends on smp_pkg and smp_ram.
`timescale 1ns / 1ps

module smp_back
  import smp_pkg::*;
#(
  parameter int PALETTE_SIZE = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  tri_t tri_in,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int PAW = $clog2(PALETTE_SIZE);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_VRD  = 4'd1;
  localparam logic [3:0] S_RRD  = 4'd2;
  localparam logic [3:0] S_VCHK = 4'd3;
  localparam logic [3:0] S_BRD  = 4'd4;
  localparam logic [3:0] S_BRRD = 4'd5;
  localparam logic [3:0] S_BCHK = 4'd6;
  localparam logic [3:0] S_VOUT = 4'd7;
  localparam logic [3:0] S_END  = 4'd8;

  logic [3:0]       state, state_next;
  logic [1:0]       corner, corner_next;
  logic [1:0]       bidx, bidx_next;
  logic             fresh, fresh_next;
  logic [15:0]      local_idx, local_idx_next;
  logic [3:0][5:0]  slots, slots_next;
  logic [16:0]      count, count_next;
  logic [6:0]       used, used_next;
  logic             vlh, vlh_next;
  logic [15:0]      span_lo, span_lo_next, span_hi, span_hi_next;
  logic             span_valid, span_valid_next;
  logic [7:0]       material, material_next;

  logic             out_load;
  res_t             res_new;

  logic [15:0]      v_cur;
  logic [9:0]       g_cur;
  logic [15:0]      vmap_rdata, vrev_rdata;
  logic [5:0]       bmap_rdata;
  logic [9:0]       brev_rdata;
  logic             vmap_we, bmap_we;
  logic             can_emit;
  logic [15:0]      nlo, nhi;
  logic             close_now, v_hit, b_hit;

  assign v_cur    = tri_in.vtx[corner];
  assign g_cur    = tri_in.bone[corner][bidx];
  assign can_emit = !out_valid || out_ready;

  smp_ram #(.WIDTH(16), .DEPTH(65536)) u_vmap (
    .clk(clk), .we(vmap_we), .waddr(v_cur), .wdata(count[15:0]),
    .raddr(v_cur), .rdata(vmap_rdata)
  );

  smp_ram #(.WIDTH(16), .DEPTH(65536)) u_vrev (
    .clk(clk), .we(vmap_we), .waddr(count[15:0]), .wdata(v_cur),
    .raddr(vmap_rdata), .rdata(vrev_rdata)
  );

  smp_ram #(.WIDTH(6), .DEPTH(1024)) u_bmap (
    .clk(clk), .we(bmap_we), .waddr(g_cur), .wdata(used[5:0]),
    .raddr(g_cur), .rdata(bmap_rdata)
  );

  smp_ram #(.WIDTH(10), .DEPTH(PALETTE_SIZE)) u_brev (
    .clk(clk), .we(bmap_we), .waddr(used[PAW-1:0]), .wdata(g_cur),
    .raddr(bmap_rdata[PAW-1:0]), .rdata(brev_rdata)
  );

  // An entry is live only if the reverse map points back at it.
  assign v_hit = ({1'b0, vmap_rdata} < count) && (vrev_rdata == v_cur);
  assign b_hit = (g_cur == '0) || (({1'b0, bmap_rdata} < used) && (brev_rdata == g_cur));

  always_comb begin
    nlo = tri_in.lo;
    nhi = tri_in.hi;
    if (span_valid) begin
      if (span_lo < nlo) nlo = span_lo;
      if (span_hi > nhi) nhi = span_hi;
    end
  end

  assign close_now = (count != '0) &&
                     (((17'(nhi) - 17'(nlo)) > 17'(VertexLimit)) || vlh ||
                      ((8'(used) + 8'd12) > 8'(PALETTE_SIZE)));

  always_comb begin
    state_next      = state;
    corner_next     = corner;
    bidx_next       = bidx;
    fresh_next      = fresh;
    local_idx_next  = local_idx;
    slots_next      = slots;
    count_next      = count;
    used_next       = used;
    vlh_next        = vlh;
    span_lo_next    = span_lo;
    span_hi_next    = span_hi;
    span_valid_next = span_valid;
    material_next   = material;
    out_load        = 1'b0;
    res_new         = '0;
    vmap_we         = 1'b0;
    bmap_we         = 1'b0;
    q_pop           = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (close_now) begin
            if (can_emit) begin
              out_load               = 1'b1;
              res_new.kind           = KIND_CLOSE;
              res_new.local_vertex   = count[15:0];
              res_new.material_index = material;
              res_new.bone_count     = used;
              count_next      = '0;
              used_next       = 7'd1;
              vlh_next        = 1'b0;
              span_lo_next    = tri_in.lo;
              span_hi_next    = tri_in.hi;
              span_valid_next = 1'b1;
              corner_next     = '0;
              state_next      = S_VRD;
            end
          end else begin
            span_lo_next    = nlo;
            span_hi_next    = nhi;
            span_valid_next = 1'b1;
            corner_next     = '0;
            state_next      = S_VRD;
          end
        end
      end
      S_VRD:  state_next = S_RRD;
      S_RRD:  state_next = S_VCHK;
      S_VCHK: begin
        fresh_next = !v_hit;
        if (!v_hit) begin
          vmap_we        = 1'b1;
          local_idx_next = count[15:0];
          count_next     = count + 17'd1;
        end else begin
          local_idx_next = vmap_rdata;
        end
        bidx_next  = '0;
        state_next = S_BRD;
      end
      S_BRD:  state_next = S_BRRD;
      S_BRRD: state_next = S_BCHK;
      S_BCHK: begin
        if (fresh && !b_hit && (used < 7'(PALETTE_SIZE))) begin
          if (can_emit) begin
            out_load             = 1'b1;
            res_new.kind         = KIND_PALETTE;
            res_new.palette_slot = used[5:0];
            res_new.global_bone  = g_cur;
            bmap_we              = 1'b1;
            slots_next[bidx]     = used[5:0];
            used_next            = used + 7'd1;
            bidx_next            = bidx + 2'd1;
            state_next           = (bidx == 2'd3) ? S_VOUT : S_BRD;
          end
        end else begin
          // Bone 0 sits at slot 0 and is never written to the map.
          slots_next[bidx] = (b_hit && (g_cur != '0)) ? bmap_rdata : 6'd0;
          bidx_next        = bidx + 2'd1;
          state_next       = (bidx == 2'd3) ? S_VOUT : S_BRD;
        end
      end
      S_VOUT: begin
        if (can_emit) begin
          out_load             = 1'b1;
          res_new.kind         = KIND_VERTEX;
          res_new.local_vertex = local_idx;
          res_new.is_new       = fresh;
          res_new.slots        = slots;
          res_new.last         = (corner == 2'd2) && !tri_in.mat_end;
          if (corner == 2'd2) begin
            state_next = S_END;
          end else begin
            corner_next = corner + 2'd1;
            state_next  = S_VRD;
          end
        end
      end
      S_END: begin
        if (tri_in.mat_end) begin
          if (can_emit) begin
            out_load               = 1'b1;
            res_new.kind           = KIND_CLOSE;
            res_new.local_vertex   = count[15:0];
            res_new.material_index = material;
            res_new.bone_count     = used;
            res_new.last           = 1'b1;
            count_next      = '0;
            used_next       = 7'd1;
            vlh_next        = 1'b0;
            material_next   = material + 8'd1;
            span_valid_next = 1'b0;
            q_pop           = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          vlh_next   = (18'(count) + 18'd3) > 18'(VertexLimit);
          q_pop      = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      corner     <= '0;
      bidx       <= '0;
      count      <= '0;
      used       <= 7'd1;
      vlh        <= 1'b0;
      span_valid <= 1'b0;
      material   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      corner     <= corner_next;
      bidx       <= bidx_next;
      count      <= count_next;
      used       <= used_next;
      vlh        <= vlh_next;
      span_valid <= span_valid_next;
      material   <= material_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fresh     <= fresh_next;
    local_idx <= local_idx_next;
    slots     <= slots_next;
    span_lo   <= span_lo_next;
    span_hi   <= span_hi_next;
    if (out_load) begin
      out_res <= res_new;
    end
  end

endmodule

// ----- sv/skinned_mesh_partitioner_unit.sv -----
// Skinned mesh partitioner, top level: front end, triangle queue, back end.
// Depends on smp_pkg, smp_front, smp_queue, smp_back.
//
// Usage
//   Slave stream takes one triangle per transfer: tdata carries three 16-bit
//   vertex indices and three 40-bit bone groups, tlast marks the last triangle
//   of a material. Master stream gives result transfers: tuser is the kind
//   (vertex, palette entry, mesh closed), tlast flags the final result of a
//   triangle.
//   Sequence: the back end walks each corner through the vertex map (read,
//   reverse read, check), then four bone lookups (read, reverse read, check
//   each), then the vertex result; closes are given out in the idle and end
//   states. The chain of dependent RAM reads sets this sequence. The first
//   result is the close when the mesh closes first, a palette entry when a new
//   vertex brings a new first bone, else a later palette entry or the vertex.
//   A two-entry queue lets the slave side keep taking triangles while the
//   back end works; the single output register lets the back end run on as
//   long as the receiver takes each result.
//   Reset: maps are empty (bone 0 at slot 0), material 0. The maps are never
//   swept: entries are checked against reverse maps and the fill counts, so
//   there is no clearing pass.
//   Receiver stall: the back end holds at its next result until tready.
`timescale 1ns / 1ps

module skinned_mesh_partitioner_unit
  import smp_pkg::*;
#(
  parameter int PALETTE_SIZE = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // vertex_a, vertex_b, vertex_c, bones_a, bones_b, bones_c
  input  logic [167:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // local_vertex, is_new, slot_first..slot_fourth, palette_slot,
  // global_bone, material_index, bone_count
  output logic [71:0]  m_tdata,
  // kind
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  tri_t tri_front, tri_head;
  logic q_full, q_valid, q_pop;
  res_t res;

  assign s_tready = !q_full;

  smp_front u_front (
    .tdata(s_tdata), .tlast(s_tlast), .tri_out(tri_front)
  );

  smp_queue u_queue (
    .clk(clk), .rst(rst),
    .push(s_tvalid && s_tready), .push_data(tri_front), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .head(tri_head)
  );

  smp_back #(.PALETTE_SIZE(PALETTE_SIZE)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .tri_in(tri_head), .q_pop(q_pop),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  // Result fields packed from the lowest bit up.
  assign m_tdata = {res.bone_count, res.material_index, res.global_bone,
                    res.palette_slot, res.slots[3], res.slots[2], res.slots[1],
                    res.slots[0], res.is_new, res.local_vertex};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

// ----- sv/smp_checker.sv -----
// Port-level checker for the skinned mesh partitioner, bound to the top level.
// Depends on smp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "skinned_mesh_partitioner_unit_defines.svh"

module smp_checker
  import smp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [71:0]  m_tdata,
  input logic [1:0]   m_tuser,
  input logic         m_tlast
);

  `SMP_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SMP_ASSERT_NOW(a_kind, clk, rst, m_tvalid, m_tuser <= KIND_CLOSE)
  `SMP_ASSERT_NOW(a_vtx_clean, clk, rst, m_tvalid && m_tuser == KIND_VERTEX, m_tdata[71:41] == '0)
  `SMP_ASSERT_NOW(a_pal_nolast, clk, rst, m_tvalid && m_tuser == KIND_PALETTE, !m_tlast && m_tdata[40:0] == '0)

endmodule

bind skinned_mesh_partitioner_unit smp_checker u_smp_checker (.*);

// ----- tb/skinned_mesh_partitioner_unit_test.sv -----
// Self-checking bench for skinned_mesh_partitioner_unit: triangles in, mesh results out.
// Depends on smp_pkg and the RTL top level; its own mesh splitter predicts every result.
`timescale 1ns / 1ps

module skinned_mesh_partitioner_unit_test;
  import smp_pkg::*;

  localparam int PaletteSize = 64;
  localparam int DrainCycles = 200;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  skinned_mesh_partitioner_unit #(.PALETTE_SIZE(PaletteSize)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted mesh state
  logic [15:0] vtx_local[int];
  logic [5:0]  bone_slot[int];
  int          slots_used;
  int          vtx_count;
  int          span_lo, span_hi;
  bit          span_ok;
  int          material;
  bit          vtx_limit;

  res_t        pending_results[$];
  int          errors = 0;
  int          results_seen = 0;
  int          closes_seen = 0;
  bit          long_hold_req = 1'b0;

  function automatic void clear_mesh();
    vtx_local.delete();
    bone_slot.delete();
    bone_slot[0] = 6'd0;
    slots_used = 1;
    vtx_count = 0;
    vtx_limit = 1'b0;
  endfunction

  function automatic res_t close_result();
    res_t r;
    r = '0;
    r.kind = KIND_CLOSE;
    r.local_vertex = vtx_count[15:0];
    r.material_index = material[7:0];
    r.bone_count = slots_used[6:0];
    return r;
  endfunction

  // Works out every result of one triangle; a typed result, if given, replaces the first.
  function automatic void split_triangle(logic [167:0] d, bit mat_end, bit has_typed,
                                         res_t typed);
    int v[3];
    int b[3][4];
    int lo, hi, nlo, nhi, g;
    res_t r;
    res_t step_q[$];
    for (int i = 0; i < 3; i++) begin
      v[i] = int'(d[16*i +: 16]);
      for (int j = 0; j < 4; j++) b[i][j] = int'(d[48 + 40*i + 10*j +: 10]);
    end
    lo = v[0]; hi = v[0];
    for (int i = 1; i < 3; i++) begin
      if (v[i] < lo) lo = v[i];
      if (v[i] > hi) hi = v[i];
    end
    nlo = lo; nhi = hi;
    if (span_ok) begin
      if (span_lo < nlo) nlo = span_lo;
      if (span_hi > nhi) nhi = span_hi;
    end
    if (vtx_count > 0 && ((nhi - nlo) > VertexLimit || vtx_limit ||
                          slots_used + 12 > PaletteSize)) begin
      step_q = {step_q, close_result()};
      clear_mesh();
      span_lo = lo; span_hi = hi;
    end else begin
      span_lo = nlo; span_hi = nhi;
    end
    span_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      res_t vr;
      vr = '0;
      vr.kind = KIND_VERTEX;
      if (!vtx_local.exists(v[i])) begin
        vr.local_vertex = vtx_count[15:0];
        vr.is_new = 1'b1;
        vtx_local[v[i]] = vtx_count[15:0];
        vtx_count++;
        for (int j = 0; j < 4; j++) begin
          g = b[i][j];
          if (!bone_slot.exists(g) && slots_used < PaletteSize) begin
            bone_slot[g] = slots_used[5:0];
            r = '0;
            r.kind = KIND_PALETTE;
            r.palette_slot = slots_used[5:0];
            r.global_bone = g[9:0];
            step_q = {step_q, r};
            slots_used++;
          end
          vr.slots[j] = bone_slot.exists(g) ? bone_slot[g] : 6'd0;
        end
      end else begin
        vr.local_vertex = vtx_local[v[i]];
        for (int j = 0; j < 4; j++)
          vr.slots[j] = bone_slot.exists(b[i][j]) ? bone_slot[b[i][j]] : 6'd0;
      end
      step_q = {step_q, vr};
    end
    vtx_limit = (vtx_count + 3 > VertexLimit);
    if (mat_end) begin
      step_q = {step_q, close_result()};
      clear_mesh();
      material = (material + 1) & 8'hff;
      span_ok = 1'b0;
    end
    step_q[step_q.size()-1].last = 1'b1;
    if (has_typed) begin
      typed.last = (step_q.size() == 1);
      step_q[0] = typed;
    end
    pending_results = {pending_results, step_q};
  endfunction

  // Sender: gap at the falling edge, hold until the transfer, then predict.
  task automatic send_triangle(logic [167:0] d, bit mat_end, int gap, bit has_typed = 0,
                               res_t typed = '0);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= mat_end;
    do @(posedge clk); while (!s_tready);
    split_triangle(d, mat_end, has_typed, typed);
  endtask

  function automatic logic [39:0] pack_bones(int b0, int b1, int b2, int b3);
    return {b3[9:0], b2[9:0], b1[9:0], b0[9:0]};
  endfunction

  function automatic logic [167:0] pack_tri(int va, int vb, int vc,
                                            logic [39:0] ba, logic [39:0] bb, logic [39:0] bc);
    return {bc, bb, ba, vc[15:0], vb[15:0], va[15:0]};
  endfunction

  // Receiver: random hold-off per result, plus one long stall on request.
  initial begin
    int wait_cycles;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (600) @(negedge clk);
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles - 1) @(negedge clk);
        @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Result checker on every accepted transfer
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser;
      got.local_vertex = m_tdata[15:0];
      got.is_new = m_tdata[16];
      for (int j = 0; j < 4; j++) got.slots[j] = m_tdata[17 + 6*j +: 6];
      got.palette_slot = m_tdata[46:41];
      got.global_bone = m_tdata[56:47];
      got.material_index = m_tdata[64:57];
      got.bone_count = m_tdata[71:65];
      got.last = m_tlast;
      results_seen++;
      if (got.kind == KIND_CLOSE) closes_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual kind %0d", $time, got.kind);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", int'(want.kind), int'(got.kind));
        check_field("local_vertex", int'(want.local_vertex), int'(got.local_vertex));
        check_field("is_new", int'(want.is_new), int'(got.is_new));
        for (int j = 0; j < 4; j++)
          check_field("slot", int'(want.slots[j]), int'(got.slots[j]));
        check_field("palette_slot", int'(want.palette_slot), int'(got.palette_slot));
        check_field("global_bone", int'(want.global_bone), int'(got.global_bone));
        check_field("material_index", int'(want.material_index), int'(got.material_index));
        check_field("bone_count", int'(want.bone_count), int'(got.bone_count));
        check_field("last", int'(want.last), int'(got.last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  typedef struct {
    logic [167:0] d;
    bit           mat_end;
    bit           has_typed;
    res_t         typed;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    res_t      t;
    int        base, pool_lo, pool_w;
    bit        wild;
    logic [39:0] bg[3];

    clear_mesh();
    span_ok = 1'b0; span_lo = 0; span_hi = 0; material = 0;

    // Directed table. First: all-zero triangle straight after reset.
    t = '0; t.kind = KIND_VERTEX; t.is_new = 1'b1;
    row = '{pack_tri(0, 0, 0, '0, '0, '0), 1'b0, 1'b1, t}; rows = {rows, row};
    // Extremes, repeated bone within a corner
    row = '{pack_tri(65535, 65535, 0, {4{10'h3ff}}, pack_bones(1023, 0, 1, 1023),
                     {40{1'b1}}), 1'b0, 1'b0, '0}; rows = {rows, row};
    row = '{pack_tri(1, 2, 3, pack_bones(5, 6, 7, 8), pack_bones(8, 9, 10, 11),
                     pack_bones(512, 256, 128, 64)), 1'b0, 1'b0, '0}; rows = {rows, row};
    // Reused vertices, bones mostly never mapped: slot 0 for those
    row = '{pack_tri(1, 2, 3, pack_bones(900, 901, 902, 903), pack_bones(5, 904, 6, 905),
                     pack_bones(906, 907, 908, 909)), 1'b1, 1'b0, '0}; rows = {rows, row};
    // Fresh mesh after a material end, new material
    t = '0; t.kind = KIND_VERTEX; t.is_new = 1'b1;
    row = '{pack_tri(5, 5, 5, '0, '0, '0), 1'b0, 1'b1, t}; rows = {rows, row};
    // Twelve new bones per triangle until the palette margin forces a close
    for (int k = 0; k < 7; k++) begin
      row = '{pack_tri(100 + 3*k, 101 + 3*k, 102 + 3*k,
                       pack_bones(20 + 12*k, 21 + 12*k, 22 + 12*k, 23 + 12*k),
                       pack_bones(24 + 12*k, 25 + 12*k, 26 + 12*k, 27 + 12*k),
                       pack_bones(28 + 12*k, 29 + 12*k, 30 + 12*k, 31 + 12*k)),
              1'b0, 1'b0, '0};
      rows = {rows, row};
    end
    row = '{pack_tri(65535, 0, 32768, {40{1'b1}}, {20{2'b10}}, {20{2'b01}}),
            1'b1, 1'b0, '0}; rows = {rows, row};
    row = '{pack_tri(7, 8, 7, pack_bones(3, 3, 3, 3), pack_bones(3, 4, 0, 4), '0),
            1'b1, 1'b0, '0}; rows = {rows, row};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send_triangle(rows[i].d, rows[i].mat_end,
                    int'($urandom_range(0, 17) * $urandom_range(0, 1)),
                    rows[i].has_typed, rows[i].typed);

    // Random part: mostly coherent meshes from a vertex window and a bone pool,
    // the rest wide random triangles.
    base = $urandom_range(0, 65535 - 64);
    pool_lo = $urandom_range(0, 1023 - 80);
    pool_w = $urandom_range(4, 80);
    for (int n = 0; n < 320; n++) begin
      wild = ($urandom_range(0, 4) == 0);
      for (int c = 0; c < 3; c++) begin
        bg[c] = '0;
        for (int j = 0; j < 4; j++)
          bg[c][10*j +: 10] = 10'(wild ? $urandom_range(0, 1023)
                                       : pool_lo + $urandom_range(0, pool_w));
      end
      row.d = wild ? pack_tri($urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), bg[0], bg[1], bg[2])
                   : pack_tri(base + $urandom_range(0, 40), base + $urandom_range(0, 40),
                              base + $urandom_range(0, 40), bg[0], bg[1], bg[2]);
      row.mat_end = ($urandom_range(0, 14) == 0);
      if (row.mat_end) begin
        base = $urandom_range(0, 65535 - 64);
        pool_lo = $urandom_range(0, 1023 - 80);
        pool_w = $urandom_range(4, 80);
      end
      if (n == 100) long_hold_req = 1'b1;
      if (n == 200) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DrainCycles) @(posedge clk);
      end
      send_triangle(row.d, row.mat_end,
                    (n % 50 < 10) ? 0 : int'($urandom_range(0, 17)));
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0) errors++;

    $display("Run covered %0d triangles, %0d results checked, %0d mesh closes.",
             rows.size() + 320, results_seen, closes_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/smp_pkg.sv
sv/smp_ram.sv
sv/smp_front.sv
sv/smp_queue.sv
sv/smp_back.sv
sv/skinned_mesh_partitioner_unit.sv
sv/smp_checker.sv
tb/skinned_mesh_partitioner_unit_test.sv
